[rtl/ptts_pkg.sv]
// Package for the periodic task tick scheduler.
// Holds request and result codes, the decoded command and the back-end state type.
// No dependencies.
package ptts_pkg;

   // request codes on req_type
   localparam logic [2:0] REQ_TICK    = 3'd0;
   localparam logic [2:0] REQ_CREATE  = 3'd1;
   localparam logic [2:0] REQ_SUSPEND = 3'd2;
   localparam logic [2:0] REQ_RESUME  = 3'd3;
   localparam logic [2:0] REQ_DELETE  = 3'd4;

   // result kinds on rsp_result_kind
   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_FIRED = 2'd1;
   localparam logic [1:0] KIND_IDLE  = 2'd2;

   localparam int SLOT_W      = 3;
   localparam int TIME_W      = 16;
   localparam int MAX_REPORTS = 8;
   localparam int REPORT_W    = 4;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_CREATE,
      OP_SUSPEND,
      OP_RESUME,
      OP_DELETE,
      OP_NOP,
      OP_REJECT
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   slot;
      logic [TIME_W-1:0]   period;
      logic [TIME_W-1:0]   first_delay;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } back_state_type;

endpackage

[rtl/ptts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ptts_front.sv]
// Front end: decodes incoming requests into commands and queues them for the back end.
// Depends on ptts_pkg.
module ptts_front import ptts_pkg::*; #(
   parameter int TASK_SLOTS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_type,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [TIME_W-1:0]   req_period,
   input  logic [TIME_W-1:0]   req_first_delay,
   output logic                cmd_valid,
   input  logic                cmd_pop,
   output cmd_type             cmd
);

   cmd_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             dec;
   logic                in_range;
   logic                push;

   assign in_range = {{(32-SLOT_W){1'b0}}, req_slot} < 32'(TASK_SLOTS);

   // classify; out-of-range slots and unknown codes only get acknowledged
   always_comb begin
      dec.slot        = req_slot;
      dec.period      = req_period;
      dec.first_delay = req_first_delay;
      unique case (req_type)
         REQ_TICK:    dec.op = OP_TICK;
         REQ_CREATE:  dec.op = in_range ? OP_CREATE  : OP_REJECT;
         REQ_SUSPEND: dec.op = in_range ? OP_SUSPEND : OP_NOP;
         REQ_RESUME:  dec.op = in_range ? OP_RESUME  : OP_NOP;
         REQ_DELETE:  dec.op = in_range ? OP_DELETE  : OP_NOP;
         default:     dec.op = OP_NOP;
      endcase
   end

   assign req_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign push      = req_valid && req_ready;
   assign cmd_valid = count_ff != '0;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

[rtl/ptts_back.sv]
// Back end: executes queued commands on the slot table and drives the result register.
// Depends on ptts_pkg and ptts_ram.
module ptts_back import ptts_pkg::*; #(
   parameter int TASK_SLOTS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_pop,
   input  cmd_type             cmd,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_result_kind,
   output logic [SLOT_W-1:0]   rsp_fired_slot,
   output logic                rsp_create_status,
   output logic                rsp_last
);

   localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W = $clog2(TASK_SLOTS + 1);

   back_state_type        state_ff, state_in;
   logic [TASK_SLOTS-1:0] valid_ff, valid_in;
   logic [TASK_SLOTS-1:0] running_ff, running_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  eval_valid_ff, eval_valid_in;
   logic [IDX_W-1:0]      eval_idx_ff, eval_idx_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;
   logic [REPORT_W-1:0]   n_ff, n_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            kind_ff, kind_in;
   logic [SLOT_W-1:0]     fired_ff, fired_in;
   logic                  status_ff, status_in;
   logic                  last_ff, last_in;

   logic                  ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]      ram_wr_addr, ram_rd_addr;
   logic [2*TIME_W-1:0]   ram_wr_data, ram_rd_data;

   logic [31:0]           cmd_slot32, eval_idx32;
   logic [IDX_W-1:0]      cmd_idx;
   logic [TIME_W-1:0]     cur_cd, cur_per, new_cd;
   logic                  out_free, due, report, go;

   // period in the upper half, countdown in the lower half
   ptts_ram #(
      .WIDTH (2*TIME_W),
      .DEPTH (TASK_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign cmd_slot32 = {{(32-SLOT_W){1'b0}}, cmd.slot};
   assign cmd_idx    = cmd_slot32[IDX_W-1:0];
   assign eval_idx32 = {{(32-IDX_W){1'b0}}, eval_idx_ff};
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign cur_cd  = ram_rd_data[TIME_W-1:0];
   assign cur_per = ram_rd_data[2*TIME_W-1:TIME_W];
   assign due     = running_ff[eval_idx_ff] && (cur_cd == '0) && valid_ff[eval_idx_ff];
   assign report  = due && (n_ff < REPORT_W'(MAX_REPORTS));
   // a new report pushes the held one out, which needs a free result register
   assign go      = !(report && pend_valid_ff) || out_free;

   always_comb begin
      if (cur_cd == '0) begin
         new_cd = valid_ff[eval_idx_ff] ? cur_per - 1'b1 : cur_cd;
      end else begin
         new_cd = cur_cd - 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      running_in    = running_ff;
      rd_idx_in     = rd_idx_ff;
      eval_valid_in = eval_valid_ff;
      eval_idx_in   = eval_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      n_in          = n_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      kind_in       = kind_ff;
      fired_in      = fired_ff;
      status_in     = status_ff;
      last_in       = last_ff;
      cmd_pop       = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rd_idx_ff[IDX_W-1:0];
      ram_wr_en     = 1'b0;
      ram_wr_addr   = eval_idx_ff;
      ram_wr_data   = {cur_per, new_cd};

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd.op == OP_TICK) begin
               cmd_pop       = 1'b1;
               ram_rd_en     = 1'b1;
               ram_rd_addr   = '0;
               rd_idx_in     = CNT_W'(1);
               eval_valid_in = 1'b1;
               eval_idx_in   = '0;
               n_in          = '0;
               pend_valid_in = 1'b0;
               state_in      = ST_WALK;
            end else if (cmd_valid && out_free) begin
               cmd_pop      = 1'b1;
               rsp_valid_in = 1'b1;
               kind_in      = KIND_ACK;
               fired_in     = '0;
               status_in    = 1'b0;
               last_in      = 1'b1;
               case (cmd.op)
                  OP_CREATE: begin
                     if (valid_ff[cmd_idx]) begin
                        status_in = 1'b1;
                     end else begin
                        valid_in[cmd_idx]   = 1'b1;
                        running_in[cmd_idx] = 1'b1;
                        ram_wr_en           = 1'b1;
                        ram_wr_addr         = cmd_idx;
                        ram_wr_data         = {cmd.period, cmd.first_delay};
                     end
                  end
                  OP_SUSPEND: running_in[cmd_idx] = 1'b0;
                  OP_RESUME:  running_in[cmd_idx] = 1'b1;
                  OP_DELETE:  valid_in[cmd_idx]   = 1'b0;
                  OP_REJECT:  status_in           = 1'b1;
                  default:    status_in           = 1'b0;
               endcase
            end
         end

         ST_WALK: begin
            if (eval_valid_ff && go) begin
               // write back the slot under evaluation if it is running
               ram_wr_en = running_ff[eval_idx_ff];
               if (report) begin
                  pend_valid_in = 1'b1;
                  pend_slot_in  = eval_idx32[SLOT_W-1:0];
                  n_in          = n_ff + 1'b1;
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     kind_in      = KIND_FIRED;
                     fired_in     = pend_slot_ff;
                     status_in    = 1'b0;
                     last_in      = 1'b0;
                  end
               end
               // advance to the next slot or finish the sweep
               if (rd_idx_ff < CNT_W'(TASK_SLOTS)) begin
                  ram_rd_en   = 1'b1;
                  eval_idx_in = rd_idx_ff[IDX_W-1:0];
                  rd_idx_in   = rd_idx_ff + 1'b1;
               end else begin
                  eval_valid_in = 1'b0;
                  state_in      = ST_FLUSH;
               end
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               kind_in       = pend_valid_ff ? KIND_FIRED : KIND_IDLE;
               fired_in      = pend_valid_ff ? pend_slot_ff : '0;
               status_in     = 1'b0;
               last_in       = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
      end else begin
         state_ff      <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         running_ff    <= '0;
         eval_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         running_ff    <= running_in;
         eval_valid_ff <= eval_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rd_idx_ff    <= rd_idx_in;
      eval_idx_ff  <= eval_idx_in;
      pend_slot_ff <= pend_slot_in;
      n_ff         <= n_in;
      kind_ff      <= kind_in;
      fired_ff     <= fired_in;
      status_ff    <= status_in;
      last_ff      <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_fired_slot    = fired_ff;
   assign rsp_create_status = status_ff;
   assign rsp_last          = last_ff;

endmodule

[rtl/periodic_task_tick_scheduler.sv]
// Periodic task tick scheduler, top level: a request front end and a slot-table back end.
// Depends on ptts_pkg, ptts_front, ptts_back (which uses ptts_ram).
//
// Keeps TASK_SLOTS task slots, each with valid and running marks, a 16-bit period and a
// 16-bit countdown; the slot number is the priority. Create, suspend, resume and delete
// each return one acknowledge transaction (create reports whether the slot was taken;
// out-of-range slots and unknown request codes are only acknowledged). A tick walks the
// slots from 0 upward, fires every valid running slot whose countdown is zero and reloads
// it to period minus one (period 0 reloads 65535); other running slots count down. Each
// firing returns one transaction in slot order, at most eight per tick, and a tick with no
// firing returns one idle transaction; the last transaction of each request carries
// rsp_last. The front end decodes requests into a two-entry command queue, so up to two
// requests are taken while the back end is busy. Periods and countdowns live in a RAM with
// one write and one registered read port. A non-tick request is executed directly; a tick
// starts by reading slot 0, sweeps the slots one per cycle while the result register can
// take each held firing, and ends by sending the final transaction. A stalled result
// channel holds both kinds of request.
module periodic_task_tick_scheduler import ptts_pkg::*; #(
   parameter int TASK_SLOTS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_type,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [TIME_W-1:0]   req_period,
   input  logic [TIME_W-1:0]   req_first_delay,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_result_kind,
   output logic [SLOT_W-1:0]   rsp_fired_slot,
   output logic                rsp_create_status,
   output logic                rsp_last
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   // decode and buffer requests
   ptts_front #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_slot        (req_slot),
      .req_period      (req_period),
      .req_first_delay (req_first_delay),
      .cmd_valid       (cmd_valid),
      .cmd_pop         (cmd_pop),
      .cmd             (cmd)
   );

   // execute commands against the slot table
   ptts_back #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd_pop           (cmd_pop),
      .cmd               (cmd),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_fired_slot    (rsp_fired_slot),
      .rsp_create_status (rsp_create_status),
      .rsp_last          (rsp_last)
   );

   // only an acknowledge can carry a create status
   a_status_only_on_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_ACK |-> !rsp_create_status)
      else $error("create status set on a non-acknowledge transaction");

   // fired slot is zero unless a task fired
   a_slot_only_on_fire: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_FIRED |-> rsp_fired_slot == '0)
      else $error("fired slot set on a non-firing transaction");

   // an idle tick and an acknowledge each close their request
   a_single_results_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_IDLE || rsp_result_kind == KIND_ACK)
      |-> rsp_last)
      else $error("single-result transaction without last");

   // a command is never taken from an empty queue
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from an empty queue");

endmodule
